// ----- rtl/cdc_pkg.sv -----
// charge deflection correction: shared types, constants and codes
// used by cdc_mul and the top level; depends on nothing
`default_nettype none
package cdc_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_EXTENT = 4;

    localparam int SIDE       = 2 * MAX_EXTENT + 1;
    localparam int TABLE_SIZE = SIDE * SIDE;
    localparam int XAW        = $clog2(MAX_WIDTH);
    localparam int YAW        = $clog2(MAX_HEIGHT);
    localparam int PAW        = XAW + YAW;
    localparam int CAW        = $clog2(4 * TABLE_SIZE);
    localparam int CB         = ((XAW > YAW) ? XAW : YAW) + 2;
    localparam int EB         = $clog2(MAX_EXTENT + 1);
    localparam int IB         = $clog2(SIDE);
    localparam int AB         = 66;
    localparam int MA         = 54;
    localparam int MB         = 48;
    localparam int MPW        = MA + MB;

    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] TAB_LEFT   = 2'd0;
    localparam logic [1:0] TAB_RIGHT  = 2'd1;
    localparam logic [1:0] TAB_BOTTOM = 2'd2;
    localparam logic [1:0] TAB_TOP    = 2'd3;

    localparam logic [1:0] REG_EXTENT = 2'd0;
    localparam logic [1:0] REG_GAIN   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic signed [39:0] OUT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] OUT_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         table_select;
        logic [3:0]         coef_col;
        logic [3:0]         coef_row;
        logic signed [47:0] coef_value;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic signed [31:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_x;
        logic [7:0]         out_y;
        logic signed [39:0] corrected_value;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic          start;
        logic [MA-1:0] a;
        logic [MB-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [MPW-1:0] p;
    } t_mul_st;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_FGET, S_NBRD, S_NBGET, S_NEIGH, S_PGET,
        S_QWAIT, S_SIDE, S_CGET, S_TWAIT, S_CWAIT, S_FIN
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/cdc_ram.sv -----
// charge deflection correction: generic ram, one write and one read port
// read data registered; depends on nothing
`default_nettype none
module cdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cdc_mul.sv -----
// charge deflection correction: shared magnitude multiplier, 16 bits of b per cycle while busy,
// top bits first; depends on cdc_pkg
`default_nettype none
module cdc_mul
    import cdc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_st       o_st
);
    logic [MA-1:0]  r_a;
    logic [MB-1:0]  r_b;
    logic [MPW-1:0] r_p;
    logic [1:0]     r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [MA+15:0] part;

    assign part = MA'(r_a) * r_b[MB-1 -: 16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_p <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[MB-17:0], 16'd0};
            r_p <= {r_p[MPW-17:0], 16'd0} + MPW'(part);
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_st.p    = r_p;
endmodule
`default_nettype wire

// ----- rtl/charge_deflection_correction_core.sv -----
// charge deflection correction top level: sequencer, registers and stores
// depends on cdc_pkg, cdc_ram and cdc_mul
//
// channels: input beats (i_in_valid/o_in_ready, payload i_in), result beats
// (o_out_valid/i_out_ready, payload o_out), config writes (i_cfg_valid/
// o_cfg_ready, index and data), always ready and applied at once.
// coefficient and pixel writes give no result.
// a read walks the (2*dmax+1)^2 neighbourhood after a setup that reads the
// pixel and its four border neighbours. a neighbour outside the image is
// skipped; one inside is scaled by the gain, then gets two more products for
// each border side whose mirrored pixel lies inside, a side being skipped
// otherwise; the single 54x16 multiplier forms every product in turn.
// a read outside the image gives a zero result without walking the neighbourhood.
// one read is worked on at a time; o_in_ready is high only while idle.
// the finished result sits in an output register, so the next beat is
// taken while it waits; a new result waits for that register to drain.
// reset restores the config registers and empties the result register;
// pixel and coefficient stores keep no reset and must be written first.
`default_nettype none
module charge_deflection_correction_core
    import cdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [2:0]  r_ext;
    logic [31:0] r_gain;
    logic [8:0]  r_wcfg, r_hcfg;

    logic signed [CB-1:0] r_x, r_y, r_w, r_h;
    logic [7:0]           r_px, r_py;
    logic [EB-1:0]        r_d;
    logic signed [EB:0]   r_ix, r_iy;
    logic signed [31:0]   r_f;
    logic signed [32:0]   r_m [4];
    logic [1:0]           r_side;
    logic signed [AB-1:0] r_acc;
    logic                 r_pneg, r_tneg, r_cneg;
    logic [39:0]          r_qmag;
    logic [MB-1:0]        r_cmag;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic in_acc, out_acc;
    logic signed [CB-1:0] cw, ch, nx, ny, bx, by, mc, lim;
    logic [EB-1:0]        cd;
    logic signed [EB:0]   sd;
    logic in_img, side_ok, m_ok, last_nb, adv_nb, adv_side;
    logic [IB-1:0]        ccol, crow;
    logic [CAW-1:0]       c_raddr, c_waddr;
    logic                 c_we, c_re, p_we, p_re;
    logic [PAW-1:0]       p_raddr, p_waddr;
    logic [31:0]          p_rdata;
    logic [MB-1:0]        c_rdata;
    t_mul_req             mreq;
    t_mul_st              mst;
    logic [53:0]          tmag;
    logic [53:0]          termag;
    logic [32:0]          mmag;
    logic signed [AB-1:0] rnd;
    logic signed [AB-9:0] res;
    logic signed [39:0]   res_sat;
    logic                 res_hit;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext  <= 3'd1;
            r_gain <= 32'd16777216;
            r_wcfg <= 9'd256;
            r_hcfg <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_EXTENT: r_ext  <= i_cfg_data[2:0];
                REG_GAIN:   r_gain <= i_cfg_data;
                REG_WIDTH:  r_wcfg <= i_cfg_data[8:0];
                REG_HEIGHT: r_hcfg <= i_cfg_data[8:0];
                default:    r_ext  <= r_ext;
            endcase
        end
    end

    always_comb begin
        if (r_wcfg == 9'd0) cw = CB'(1);
        else if (int'(r_wcfg) > MAX_WIDTH) cw = CB'(MAX_WIDTH);
        else cw = CB'(r_wcfg);
        if (r_hcfg == 9'd0) ch = CB'(1);
        else if (int'(r_hcfg) > MAX_HEIGHT) ch = CB'(MAX_HEIGHT);
        else ch = CB'(r_hcfg);
        cd = (int'(r_ext) > MAX_EXTENT) ? EB'(MAX_EXTENT) : EB'(r_ext);
    end

    // stores
    assign c_we    = in_acc && (i_in.operation == OP_COEF)
                     && (int'(i_in.coef_col) < SIDE) && (int'(i_in.coef_row) < SIDE);
    assign c_waddr = CAW'(i_in.table_select) * CAW'(TABLE_SIZE)
                     + CAW'(i_in.coef_row) * CAW'(SIDE) + CAW'(i_in.coef_col);
    assign p_we    = in_acc && (i_in.operation == OP_PIXEL)
                     && (int'(i_in.pixel_x) < MAX_WIDTH) && (int'(i_in.pixel_y) < MAX_HEIGHT);
    assign p_waddr = {YAW'(i_in.pixel_y), XAW'(i_in.pixel_x)};

    cdc_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_pix (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (i_in.pixel_value),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    cdc_ram #(.WIDTH(MB), .DEPTH(4 * TABLE_SIZE)) u_coef (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_in.coef_value),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    cdc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_st    (mst)
    );

    // neighbourhood geometry
    assign sd      = signed'({1'b0, r_d});
    assign nx      = r_x + CB'(r_ix);
    assign ny      = r_y + CB'(r_iy);
    assign in_img  = (nx >= 0) && (nx < r_w) && (ny >= 0) && (ny < r_h);
    assign last_nb = (r_ix == sd) && (r_iy == sd);
    assign ccol    = IB'(r_ix + sd);
    assign crow    = IB'(r_iy + sd);
    assign c_raddr = CAW'(r_side) * CAW'(TABLE_SIZE) + CAW'(crow) * CAW'(SIDE) + CAW'(ccol);

    always_comb begin
        bx   = r_x;
        by   = r_y;
        mc   = r_x - CB'(1) - CB'(r_ix);
        lim  = r_w;
        m_ok = (r_x > 0);
        unique case (r_side)
            TAB_LEFT: begin
                bx = r_x - CB'(1);
            end
            TAB_RIGHT: begin
                bx   = r_x + CB'(1);
                mc   = r_x + CB'(1) - CB'(r_ix);
                m_ok = (r_x < r_w - CB'(1));
            end
            TAB_BOTTOM: begin
                by   = r_y - CB'(1);
                mc   = r_y - CB'(1) - CB'(r_iy);
                lim  = r_h;
                m_ok = (r_y > 0);
            end
            TAB_TOP: begin
                by   = r_y + CB'(1);
                mc   = r_y + CB'(1) - CB'(r_iy);
                lim  = r_h;
                m_ok = (r_y < r_h - CB'(1));
            end
            default: begin
                bx = r_x;
            end
        endcase
        side_ok = (mc >= 0) && (mc < lim);
    end

    // product handling
    assign mmag   = r_m[r_side][32] ? 33'(-r_m[r_side]) : 33'(r_m[r_side]);
    assign tmag   = (|mst.p[MPW-1:54]) ? {54{1'b1}} : mst.p[53:0];
    assign termag = mst.p[MPW-1] ? {54{1'b1}} : mst.p[MPW-2:47];

    // final scaling, truncation toward zero and saturation to 40 bits
    assign rnd     = r_acc[AB-1] ? r_acc + AB'(255) : r_acc;
    assign res     = rnd[AB-1:8];
    assign res_hit = (res > (AB-8)'(OUT_MAX)) || (res < (AB-8)'(OUT_MIN));
    assign res_sat = (res > (AB-8)'(OUT_MAX)) ? OUT_MAX
                   : ((res < (AB-8)'(OUT_MIN)) ? OUT_MIN : res[39:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        p_re       = 1'b0;
        p_raddr    = {YAW'(r_y), XAW'(r_x)};
        c_re       = 1'b0;
        mreq.start = 1'b0;
        mreq.a     = MA'(r_qmag);
        mreq.b     = MB'(mmag);
        adv_nb     = 1'b0;
        adv_side   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.operation == OP_READ) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_x >= r_w || r_y >= r_h) begin
                    n_state = S_FIN;
                end else begin
                    p_re    = 1'b1;
                    n_state = S_FGET;
                end
            end
            S_FGET: begin
                n_state = S_NBRD;
            end
            S_NBRD: begin
                p_re    = 1'b1;
                p_raddr = {YAW'(by), XAW'(bx)};
                n_state = S_NBGET;
            end
            S_NBGET: begin
                n_state = (r_side == TAB_TOP) ? S_NEIGH : S_NBRD;
            end
            S_NEIGH: begin
                if (in_img) begin
                    p_re    = 1'b1;
                    p_raddr = {YAW'(ny), XAW'(nx)};
                    n_state = S_PGET;
                end else begin
                    adv_nb  = 1'b1;
                    n_state = last_nb ? S_FIN : S_NEIGH;
                end
            end
            S_PGET: begin
                mreq.start = 1'b1;
                mreq.a     = MA'(p_rdata[31] ? 32'(-p_rdata) : p_rdata);
                mreq.b     = MB'(r_gain);
                n_state    = S_QWAIT;
            end
            S_QWAIT: begin
                if (mst.done) begin
                    n_state = S_SIDE;
                end
            end
            S_SIDE: begin
                if (side_ok) begin
                    c_re    = 1'b1;
                    n_state = S_CGET;
                end else begin
                    adv_side = 1'b1;
                end
            end
            S_CGET: begin
                mreq.start = 1'b1;
                n_state    = S_TWAIT;
            end
            S_TWAIT: begin
                if (mst.done) begin
                    mreq.start = 1'b1;
                    mreq.a     = tmag;
                    mreq.b     = r_cmag;
                    n_state    = S_CWAIT;
                end
            end
            S_CWAIT: begin
                if (mst.done) begin
                    adv_side = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (adv_side) begin
            if (r_side == TAB_TOP) begin
                adv_nb  = 1'b1;
                n_state = last_nb ? S_FIN : S_NEIGH;
            end else begin
                n_state = S_SIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x  <= CB'(i_in.pixel_x);
                r_y  <= CB'(i_in.pixel_y);
                r_px <= i_in.pixel_x;
                r_py <= i_in.pixel_y;
                r_w  <= cw;
                r_h  <= ch;
                r_d  <= cd;
                r_acc <= '0;
            end
            S_FGET: begin
                r_f    <= p_rdata;
                r_side <= TAB_LEFT;
            end
            S_NBGET: begin
                r_m[r_side] <= m_ok ? 33'(r_f) + 33'(signed'(p_rdata)) : '0;
                r_side      <= r_side + 2'd1;
                if (r_side == TAB_TOP) begin
                    r_acc <= AB'(r_f) <<< 8;
                    r_ix  <= -sd;
                    r_iy  <= -sd;
                end
            end
            S_PGET: begin
                r_pneg <= p_rdata[31];
            end
            S_QWAIT: begin
                r_qmag <= mst.p[63:24];
                r_side <= TAB_LEFT;
            end
            S_CGET: begin
                r_cneg <= c_rdata[MB-1];
                r_cmag <= c_rdata[MB-1] ? MB'(-c_rdata) : c_rdata;
                r_tneg <= r_pneg ^ r_m[r_side][32];
            end
            S_TWAIT: begin
                if (mst.done) begin
                    r_tneg <= r_tneg ^ r_cneg;
                end
            end
            S_CWAIT: begin
                if (mst.done) begin
                    r_acc <= r_tneg ? r_acc - AB'(termag) : r_acc + AB'(termag);
                end
            end
            default: begin
            end
        endcase
        if (adv_side) begin
            r_side <= r_side + 2'd1;
        end
        if (adv_nb) begin
            if (r_ix == sd) begin
                r_ix <= -sd;
                r_iy <= r_iy + (EB+1)'(1);
            end else begin
                r_ix <= r_ix + (EB+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
            r_out.out_x           <= r_px;
            r_out.out_y           <= r_py;
            r_out.corrected_value <= res_sat;
            r_out.saturated       <= res_hit;
        end
    end

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mreq.start |-> !mst.busy)
        else $error("multiplier started while busy");

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.operation == OP_READ |=> r_state == S_CHK)
        else $error("read beat did not start the sequencer");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.saturated |->
            (r_out.corrected_value == OUT_MAX || r_out.corrected_value == OUT_MIN))
        else $error("saturated result not at a bound");
endmodule
`default_nettype wire
